// ----- rtl/scs1a_pkg.sv -----
// Shared types and constants for the scan code set 1 to ASCII core.
// Holds the key codes, both keymap ROMs and the decode result struct.
// No dependencies.
package scs1a_pkg;

    localparam int unsigned KeyW     = 7;
    localparam int unsigned CharW    = 7;
    localparam int unsigned RomDepth = 58;
    localparam int unsigned RomIdxW  = 6;

    localparam logic [KeyW-1:0]  KEY_LSHIFT = 7'h2A;
    localparam logic [KeyW-1:0]  KEY_RSHIFT = 7'h36;
    localparam logic [KeyW-1:0]  KEY_CAPS   = 7'h3A;
    localparam logic [KeyW-1:0]  KEY_LAST   = 7'd57;
    localparam logic [CharW-1:0] CHAR_NONE  = 7'h00;
    localparam logic [CharW-1:0] CHAR_LC_A  = 7'h61;
    localparam logic [CharW-1:0] CHAR_LC_Z  = 7'h7A;
    localparam logic [CharW-1:0] CASE_BIT   = 7'h20;

    localparam logic [CharW-1:0] ROM_PLAIN [0:RomDepth-1] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam logic [CharW-1:0] ROM_SHIFT [0:RomDepth-1] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    typedef struct packed {
        logic             emit;
        logic [CharW-1:0] ascii_char;
        logic             shift_next;
        logic             caps_next;
    } t_dec_result;

endpackage

// ----- rtl/scs1a_decode.sv -----
// Combinational decode of one scan byte against the current shift/caps flags.
// Depends on scs1a_pkg for key codes, keymap ROMs and t_dec_result.
module scs1a_decode
    import scs1a_pkg::*;
(
    input  logic [7:0]  i_scan_byte,
    input  logic        i_shift_held,
    input  logic        i_caps_locked,
    output t_dec_result o_result
);

    logic             release_bit;
    logic [KeyW-1:0]  key;
    logic [RomIdxW-1:0] idx;
    logic [CharW-1:0] plain_char;
    logic [CharW-1:0] shift_char;
    logic [CharW-1:0] mapped_char;
    logic             is_letter;

    assign release_bit = i_scan_byte[7];
    assign key         = i_scan_byte[KeyW-1:0];
    assign idx         = key[RomIdxW-1:0];

    always_comb begin
        if (key <= KEY_LAST) begin
            plain_char = ROM_PLAIN[idx];
            shift_char = ROM_SHIFT[idx];
        end else begin
            plain_char = CHAR_NONE;
            shift_char = CHAR_NONE;
        end
    end

    assign is_letter = (plain_char >= CHAR_LC_A) && (plain_char <= CHAR_LC_Z);

    // Letters follow shift XOR caps; everything else follows shift alone.
    always_comb begin
        if (is_letter) begin
            mapped_char = (i_shift_held ^ i_caps_locked) ? (plain_char & ~CASE_BIT)
                                                         : plain_char;
        end else begin
            mapped_char = i_shift_held ? shift_char : plain_char;
        end
    end

    always_comb begin
        o_result.emit       = 1'b0;
        o_result.ascii_char = mapped_char;
        o_result.shift_next = i_shift_held;
        o_result.caps_next  = i_caps_locked;
        if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
            o_result.shift_next = ~release_bit;
        end else if (key == KEY_CAPS && !release_bit) begin
            o_result.caps_next = ~i_caps_locked;
        end else if (!release_bit) begin
            o_result.emit = (mapped_char != CHAR_NONE);
        end
    end

endmodule

// ----- rtl/scancode_set1_to_ascii_core.sv -----
// Channel   Valid    Stall    Payload
// in        i_valid  o_stall  i_scan_byte[7:0]
// out       o_valid  i_stall  o_ascii_char[6:0]
//
// One scan byte per cycle sustained while the result is not stalled; an input
// register feeds the keymap decode, which loads the result register. Shift and
// caps flags update as each byte leaves the input register.
// Synchronous active-low reset clears valids and both flags.
// A stalled result holds the input register; o_stall rises only while both
// stages are full and the result is stalled.
// Depends on scs1a_pkg and scs1a_decode.
module scancode_set1_to_ascii_core
    import scs1a_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_scan_byte,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [CharW-1:0] o_ascii_char
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_shift_held;
    logic             r_caps_locked;
    logic             r_out_valid;
    logic [CharW-1:0] r_out_char;
    logic             advance;
    t_dec_result      dec;

    scs1a_decode u_decode (
        .i_scan_byte   (r_in_byte),
        .i_shift_held  (r_shift_held),
        .i_caps_locked (r_caps_locked),
        .o_result      (dec)
    );

    // Advance the input stage whenever the result register is free or draining.
    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_shift_held  <= 1'b0;
            r_caps_locked <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid && dec.emit;
                if (r_in_valid) begin
                    r_shift_held  <= dec.shift_next;
                    r_caps_locked <= dec.caps_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_scan_byte;
        end
        if (advance && r_in_valid) begin
            r_out_char <= dec.ascii_char;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_ascii_char = r_out_char;

    a_release_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && advance && r_in_byte[7] |=> !o_valid)
        else $error("release byte produced a result");

    a_caps_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && advance && r_in_byte == {1'b0, KEY_CAPS}
        |=> r_caps_locked != $past(r_caps_locked))
        else $error("caps press did not toggle caps lock");

    a_shift_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && advance &&
        (r_in_byte == {1'b0, KEY_LSHIFT} || r_in_byte == {1'b0, KEY_RSHIFT})
        |=> r_shift_held && !o_valid)
        else $error("shift press mishandled");

    a_nonzero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_ascii_char != CHAR_NONE)
        else $error("zero character delivered");

endmodule
